// ===== design/hbsdl_pkg.sv =====
// Shared types and constants for the hall bus scan, debounce and latch block.
// Depends on nothing; every other file in the design imports it.
package hbsdl_pkg;

    localparam int SAMPLE_BITS    = 12;
    localparam int THRESH_W       = SAMPLE_BITS + 1;
    localparam int EXIST_W        = 8;
    localparam int ACTIVE_W       = 7;
    localparam int TALLY_W        = 16;
    localparam int COUNT_W        = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 12;
    localparam int DEVICE_SLOTS_D = 8;

    localparam logic [SAMPLE_BITS-1:0] QOFFSET_RST   = 12'd1024;
    localparam logic [SAMPLE_BITS-1:0] FAULT_HI_RST  = 12'd3755;
    localparam logic [SAMPLE_BITS-1:0] FAULT_LO_RST  = 12'd341;
    localparam logic [COUNT_W-1:0]     DEBOUNCE_RST  = 4'd3;
    localparam logic [ACTIVE_W-1:0]    LATCH_MSK_RST = 7'h7F;
    localparam logic [TALLY_W-1:0]     TALLY_SETTLED = 16'd1000;
    localparam logic [TALLY_W-1:0]     TALLY_MAX     = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_QUIESCENT_OFFSET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_HIGH_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_LOW_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_SCANS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ASSERT_MASK_A    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ASSERT_MASK_B    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH_MASK       = 3'd6;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_a;
        logic [SAMPLE_BITS-1:0] sample_b;
    } t_scan_in;

    typedef struct packed {
        logic                 bus_reset_pin;
        logic                 bus_address_pin;
        logic [EXIST_W-1:0]   exist_a;
        logic [ACTIVE_W-1:0]  active_a;
        logic [ACTIVE_W-1:0]  latch_a;
        logic                 event_a;
        logic [EXIST_W-1:0]   exist_b;
        logic [ACTIVE_W-1:0]  active_b;
        logic [ACTIVE_W-1:0]  latch_b;
        logic                 event_b;
        logic [TALLY_W-1:0]   change_tally_a;
        logic [TALLY_W-1:0]   change_tally_b;
    } t_scan_out;

    typedef struct packed {
        logic                quiescent;
        logic                exist_step;
        logic                active_step;
        logic                settle;
        logic [EXIST_W-1:0]  slot_exist;
        logic [ACTIVE_W-1:0] slot_active;
    } t_scan_ctl;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] quiescent_offset;
        logic [SAMPLE_BITS-1:0] fault_high_limit;
        logic [SAMPLE_BITS-1:0] fault_low_limit;
        logic [COUNT_W-1:0]     debounce_scans;
        logic [ACTIVE_W-1:0]    assert_mask;
        logic [ACTIVE_W-1:0]    latch_mask;
    } t_bus_cfg;

    typedef struct packed {
        logic [EXIST_W-1:0]  exist;
        logic [ACTIVE_W-1:0] active;
        logic [ACTIVE_W-1:0] latch;
        logic                event_flag;
        logic [TALLY_W-1:0]  tally;
    } t_bus_out;

endpackage

// ===== design/hbsdl_bus.sv =====
// One hall bus: threshold capture, pattern build, debounce, publish and latch.
// Depends on hbsdl_pkg; instanced once per bus by the top level.
module hbsdl_bus (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  hbsdl_pkg::t_scan_ctl            i_ctl,
    input  hbsdl_pkg::t_bus_cfg             i_cfg,
    input  logic [hbsdl_pkg::SAMPLE_BITS-1:0] i_sample,
    output hbsdl_pkg::t_bus_out             o_bus
);
    import hbsdl_pkg::*;

    logic [THRESH_W-1:0] r_thresh, n_thresh;
    logic [EXIST_W-1:0]  r_scan_exist, n_scan_exist, r_prev_exist, n_prev_exist;
    logic [EXIST_W-1:0]  r_pub_exist, n_pub_exist;
    logic [ACTIVE_W-1:0] r_scan_active, n_scan_active, r_prev_active, n_prev_active;
    logic [ACTIVE_W-1:0] r_pub_active, n_pub_active, r_prev_latch, n_prev_latch;
    logic [ACTIVE_W-1:0] r_latch, n_latch;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [TALLY_W-1:0]  r_tally, n_tally;
    logic                r_event, n_event;

    logic                hit;
    logic                differs;
    logic                same_prev;
    logic [ACTIVE_W-1:0] fresh;
    logic [ACTIVE_W-1:0] fresh_latch;

    assign hit = {1'b0, i_sample} > r_thresh;

    always_comb begin
        n_thresh      = r_thresh;
        n_scan_exist  = r_scan_exist;
        n_scan_active = r_scan_active;
        n_prev_exist  = r_prev_exist;
        n_prev_active = r_prev_active;
        n_pub_exist   = r_pub_exist;
        n_pub_active  = r_pub_active;
        n_prev_latch  = r_prev_latch;
        n_latch       = r_latch;
        n_count       = r_count;
        n_tally       = r_tally;
        n_event       = 1'b0;
        fresh         = '0;
        fresh_latch   = '0;
        differs       = 1'b0;
        same_prev     = 1'b0;

        if (i_ctl.quiescent) begin
            n_scan_exist  = '0;
            n_scan_active = '0;
            n_thresh      = {1'b0, i_sample} + {1'b0, i_cfg.quiescent_offset};
            n_event       = (i_sample > i_cfg.fault_high_limit) ||
                            (i_sample < i_cfg.fault_low_limit);
        end
        if (i_ctl.exist_step && hit) begin
            n_scan_exist = r_scan_exist | i_ctl.slot_exist;
        end
        if (i_ctl.active_step && hit) begin
            n_scan_active = r_scan_active | i_ctl.slot_active;
        end

        if (i_ctl.settle) begin
            differs   = (n_scan_exist != r_pub_exist) || (n_scan_active != r_pub_active);
            same_prev = (n_scan_exist == r_prev_exist) && (n_scan_active == r_prev_active);
            if (differs) begin
                if (r_count == '0) begin
                    n_count = i_cfg.debounce_scans;
                    n_tally = r_tally + TALLY_W'(1);
                end else if (same_prev) begin
                    n_count = r_count - COUNT_W'(1);
                    if ((n_count == '0) && (r_tally != TALLY_MAX)) begin
                        n_tally = r_tally + TALLY_SETTLED;
                    end
                end else begin
                    n_count = i_cfg.debounce_scans;
                    n_tally = r_tally + TALLY_W'(1);
                end
                n_prev_exist  = n_scan_exist;
                n_prev_active = n_scan_active;
            end else begin
                n_count = '0;
            end
            if (n_count == '0) begin
                n_pub_exist  = n_scan_exist;
                n_pub_active = n_scan_active;
                fresh        = n_scan_active & ~r_prev_latch;
                fresh_latch  = fresh & i_cfg.latch_mask;
                if ((fresh & i_cfg.assert_mask) != '0) begin
                    n_event = 1'b1;
                end
                if (fresh_latch != '0) begin
                    n_latch = (r_latch != '0) ? '0 : fresh_latch;
                end
                n_prev_latch = n_scan_active & i_cfg.latch_mask;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh      <= '0;
            r_scan_exist  <= '0;
            r_scan_active <= '0;
            r_prev_exist  <= '0;
            r_prev_active <= '0;
            r_pub_exist   <= '0;
            r_pub_active  <= '0;
            r_prev_latch  <= '0;
            r_latch       <= '0;
            r_count       <= '0;
            r_tally       <= '0;
            r_event       <= 1'b0;
        end else if (i_accept) begin
            r_thresh      <= n_thresh;
            r_scan_exist  <= n_scan_exist;
            r_scan_active <= n_scan_active;
            r_prev_exist  <= n_prev_exist;
            r_prev_active <= n_prev_active;
            r_pub_exist   <= n_pub_exist;
            r_pub_active  <= n_pub_active;
            r_prev_latch  <= n_prev_latch;
            r_latch       <= n_latch;
            r_count       <= n_count;
            r_tally       <= n_tally;
            r_event       <= n_event;
        end
    end

    assign o_bus.exist      = r_pub_exist;
    assign o_bus.active     = r_pub_active;
    assign o_bus.latch      = r_latch;
    assign o_bus.event_flag = r_event;
    assign o_bus.tally      = r_tally;

endmodule

// ===== design/hall_bus_scan_debounce_latch_core.sv =====
// Top level: scan sequencer, configuration registers and result handshake.
// Depends on hbsdl_pkg and hbsdl_bus.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one scan tick
//   word holding a converter sample from each of the two hall buses.
//   Output channel (o_out_valid / i_out_ready / o_out_data) gives exactly one
//   result word per tick: bus pin levels, published exist/active patterns,
//   latch states, event flags and change tallies for both buses.
//   Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_index /
//   i_cfg_data) writes one register per word; it is always ready and must
//   only be used while no result is pending.
//   A word's result is registered and shows in the cycle after it is taken.
//   Throughput is one word per cycle when not stalled; the whole step is one
//   pass of compare and bit logic into the state registers, which also hold
//   the result. A new word is taken while the held result is being taken in
//   the same cycle; while the receiver stalls the result holds and input is
//   refused. Reset clears the sequencer to step one, all per-bus state to
//   zero, and loads the configuration registers with their defaults.
module hall_bus_scan_debounce_latch_core #(
    parameter int DEVICE_SLOTS = hbsdl_pkg::DEVICE_SLOTS_D
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  hbsdl_pkg::t_scan_in              i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output hbsdl_pkg::t_scan_out             o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [hbsdl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hbsdl_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import hbsdl_pkg::*;

    localparam int LAST_STEP = 2 * DEVICE_SLOTS + 2;
    localparam int STEP_W    = $clog2(LAST_STEP + 1);
    localparam logic [EXIST_W-1:0]  EXIST_MASK  = EXIST_W'((1 << DEVICE_SLOTS) - 1);
    localparam logic [ACTIVE_W-1:0] ACTIVE_MASK = ACTIVE_W'((1 << (DEVICE_SLOTS - 1)) - 1);

    logic [STEP_W-1:0]      r_step, n_step;
    logic [EXIST_W-1:0]     r_slot, n_slot;
    logic                   r_reset_line, n_reset_line;
    logic                   r_addr_line, n_addr_line;
    logic                   r_out_valid;

    logic [SAMPLE_BITS-1:0] r_qoffset, r_fault_hi, r_fault_lo;
    logic [COUNT_W-1:0]     r_debounce;
    logic [ACTIVE_W-1:0]    r_assert_a, r_assert_b, r_latch_mask;

    logic                   in_accept;
    logic                   cfg_accept;
    logic                   scan_step;
    t_scan_ctl              ctl;
    t_bus_cfg               cfg_a, cfg_b;
    t_bus_out               bus_a, bus_b;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign cfg_accept  = i_cfg_valid;

    assign scan_step = (r_step >= STEP_W'(4));

    always_comb begin
        ctl.quiescent   = (r_step == STEP_W'(3));
        ctl.exist_step  = scan_step && !r_step[0];
        ctl.active_step = scan_step && r_step[0];
        ctl.settle      = (r_step == STEP_W'(LAST_STEP));
        ctl.slot_exist  = r_slot & EXIST_MASK;
        ctl.slot_active = r_slot[ACTIVE_W-1:0] & ACTIVE_MASK;
    end

    always_comb begin
        n_reset_line = r_reset_line;
        n_addr_line  = r_addr_line;
        n_slot       = r_slot;
        n_step       = ctl.settle ? STEP_W'(1) : r_step + STEP_W'(1);
        if (r_step == STEP_W'(1)) begin
            n_reset_line = 1'b1;
        end else if (r_step == STEP_W'(2)) begin
            n_reset_line = 1'b0;
        end else if (ctl.quiescent) begin
            n_slot      = EXIST_W'(1);
            n_addr_line = 1'b0;
        end else if (ctl.exist_step) begin
            n_addr_line = 1'b1;
        end else if (ctl.active_step) begin
            n_slot      = r_slot << 1;
            n_addr_line = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= STEP_W'(1);
            r_slot       <= EXIST_W'(1);
            r_reset_line <= 1'b0;
            r_addr_line  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_accept) begin
                r_step       <= n_step;
                r_slot       <= n_slot;
                r_reset_line <= n_reset_line;
                r_addr_line  <= n_addr_line;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qoffset    <= QOFFSET_RST;
            r_fault_hi   <= FAULT_HI_RST;
            r_fault_lo   <= FAULT_LO_RST;
            r_debounce   <= DEBOUNCE_RST;
            r_assert_a   <= '0;
            r_assert_b   <= '0;
            r_latch_mask <= LATCH_MSK_RST;
        end else if (cfg_accept) begin
            unique case (i_cfg_index)
                CFG_QUIESCENT_OFFSET: r_qoffset    <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_FAULT_HIGH_LIMIT: r_fault_hi   <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_FAULT_LOW_LIMIT:  r_fault_lo   <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_DEBOUNCE_SCANS:   r_debounce   <= i_cfg_data[COUNT_W-1:0];
                CFG_ASSERT_MASK_A:    r_assert_a   <= i_cfg_data[ACTIVE_W-1:0];
                CFG_ASSERT_MASK_B:    r_assert_b   <= i_cfg_data[ACTIVE_W-1:0];
                CFG_LATCH_MASK:       r_latch_mask <= i_cfg_data[ACTIVE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg_a.quiescent_offset = r_qoffset;
        cfg_a.fault_high_limit = r_fault_hi;
        cfg_a.fault_low_limit  = r_fault_lo;
        cfg_a.debounce_scans   = r_debounce;
        cfg_a.assert_mask      = r_assert_a;
        cfg_a.latch_mask       = r_latch_mask;
        cfg_b                  = cfg_a;
        cfg_b.assert_mask      = r_assert_b;
    end

    hbsdl_bus u_bus_a (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_ctl    (ctl),
        .i_cfg    (cfg_a),
        .i_sample (i_in_data.sample_a),
        .o_bus    (bus_a)
    );

    hbsdl_bus u_bus_b (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_ctl    (ctl),
        .i_cfg    (cfg_b),
        .i_sample (i_in_data.sample_b),
        .o_bus    (bus_b)
    );

    assign o_out_valid = r_out_valid;

    always_comb begin
        o_out_data.bus_reset_pin   = r_reset_line;
        o_out_data.bus_address_pin = r_addr_line;
        o_out_data.exist_a         = bus_a.exist;
        o_out_data.active_a        = bus_a.active;
        o_out_data.latch_a         = bus_a.latch;
        o_out_data.event_a         = bus_a.event_flag;
        o_out_data.exist_b         = bus_b.exist;
        o_out_data.active_b        = bus_b.active;
        o_out_data.latch_b         = bus_b.latch;
        o_out_data.event_b         = bus_b.event_flag;
        o_out_data.change_tally_a  = bus_a.tally;
        o_out_data.change_tally_b  = bus_b.tally;
    end

endmodule

// ===== design/hbsdl_checker.sv =====
// Port-level checks for the hall bus scan core, attached by bind.
// Depends on hbsdl_pkg and the top level's port list.
module hbsdl_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_ready,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input hbsdl_pkg::t_scan_out             o_out_data
);
    import hbsdl_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result word changed while stalled");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input refused with empty result stage");

    a_word_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted word produced no result");

endmodule

bind hall_bus_scan_debounce_latch_core hbsdl_checker u_hbsdl_checker (.*);

// ===== test/tb_hall_bus_scan_debounce_latch_core.sv =====
// Self-checking bench for hall_bus_scan_debounce_latch_core: scan frames, noise and
// register settings go in, every result word is checked against a built-in predictor.
// Depends on hbsdl_pkg and the design files only.
`timescale 1ns / 1ps

module tb_hall_bus_scan_debounce_latch_core;

    import hbsdl_pkg::*;

    localparam int SCAN_STEPS  = 2 * DEVICE_SLOTS_D + 2;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [THRESH_W-1:0] thresh;
        logic [EXIST_W-1:0]  scan_exist;
        logic [EXIST_W-1:0]  prev_exist;
        logic [EXIST_W-1:0]  pub_exist;
        logic [ACTIVE_W-1:0] scan_active;
        logic [ACTIVE_W-1:0] prev_active;
        logic [ACTIVE_W-1:0] pub_active;
        logic [ACTIVE_W-1:0] prev_latch;
        logic [ACTIVE_W-1:0] latch;
        logic [COUNT_W-1:0]  settle;
        logic [TALLY_W-1:0]  tally;
    } t_bus_track;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_scan_in              in_word;
    logic                  out_valid;
    logic                  out_ready;
    t_scan_out             out_word;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int unsigned         step_no;
    logic [EXIST_W-1:0]  slot_sel;
    logic                reset_lvl;
    logic                addr_lvl;
    t_bus_track          bus_trk [2];
    logic [SAMPLE_BITS-1:0] cfg_qoffset;
    logic [SAMPLE_BITS-1:0] cfg_fault_hi;
    logic [SAMPLE_BITS-1:0] cfg_fault_lo;
    logic [COUNT_W-1:0]     cfg_debounce;
    logic [ACTIVE_W-1:0]    cfg_amask [2];
    logic [ACTIVE_W-1:0]    cfg_latch_mask;

    t_scan_out scan_results_due [$];
    int        mismatches;
    int        results_checked;
    int        ticks_sent;
    int        frames_sent;
    int        settings_applied;
    int        events_seen;
    int        cycle_count;
    int        hold_cycles;
    int        longest_hold;
    bit        stall_enable;

    hall_bus_scan_debounce_latch_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic reset_predictor();
        step_no        = 1;
        slot_sel       = 1;
        reset_lvl      = 1'b0;
        addr_lvl       = 1'b0;
        cfg_qoffset    = QOFFSET_RST;
        cfg_fault_hi   = FAULT_HI_RST;
        cfg_fault_lo   = FAULT_LO_RST;
        cfg_debounce   = DEBOUNCE_RST;
        cfg_amask[0]   = '0;
        cfg_amask[1]   = '0;
        cfg_latch_mask = LATCH_MSK_RST;
        for (int i = 0; i < 2; i++) begin
            bus_trk[i] = '{default: '0};
        end
    endtask

    function automatic logic settle_bus(int b, logic [ACTIVE_W-1:0] amask);
        logic [ACTIVE_W-1:0] fresh;
        logic                ev;
        ev = 1'b0;
        if (bus_trk[b].scan_exist != bus_trk[b].pub_exist ||
            bus_trk[b].scan_active != bus_trk[b].pub_active) begin
            if (bus_trk[b].settle == 0) begin
                bus_trk[b].settle = cfg_debounce;
                bus_trk[b].tally  = bus_trk[b].tally + 16'd1;
            end else if (bus_trk[b].scan_exist == bus_trk[b].prev_exist &&
                         bus_trk[b].scan_active == bus_trk[b].prev_active) begin
                bus_trk[b].settle = bus_trk[b].settle - 4'd1;
                if (bus_trk[b].settle == 0 && bus_trk[b].tally != TALLY_MAX)
                    bus_trk[b].tally = bus_trk[b].tally + TALLY_SETTLED;
            end else begin
                bus_trk[b].settle = cfg_debounce;
                bus_trk[b].tally  = bus_trk[b].tally + 16'd1;
            end
            bus_trk[b].prev_exist  = bus_trk[b].scan_exist;
            bus_trk[b].prev_active = bus_trk[b].scan_active;
        end else begin
            bus_trk[b].settle = '0;
        end
        if (bus_trk[b].settle == 0) begin
            bus_trk[b].pub_exist  = bus_trk[b].scan_exist;
            bus_trk[b].pub_active = bus_trk[b].scan_active;
            fresh = bus_trk[b].pub_active & ~bus_trk[b].prev_latch;
            if ((fresh & amask) != 0)
                ev = 1'b1;
            fresh = fresh & cfg_latch_mask;
            if (fresh != 0)
                bus_trk[b].latch = (bus_trk[b].latch != 0) ? '0 : fresh;
            bus_trk[b].prev_latch = bus_trk[b].scan_active & cfg_latch_mask;
        end
        return ev;
    endfunction

    function automatic t_scan_out predict_scan_tick(t_scan_in w);
        logic [SAMPLE_BITS-1:0] s [2];
        logic                   ev [2];
        t_scan_out              r;
        s[0]  = w.sample_a;
        s[1]  = w.sample_b;
        ev[0] = 1'b0;
        ev[1] = 1'b0;
        if (step_no == 1) begin
            reset_lvl = 1'b1;
        end else if (step_no == 2) begin
            reset_lvl = 1'b0;
        end else if (step_no == 3) begin
            slot_sel = 1;
            for (int i = 0; i < 2; i++) begin
                bus_trk[i].scan_exist  = '0;
                bus_trk[i].scan_active = '0;
                if (s[i] > cfg_fault_hi || s[i] < cfg_fault_lo)
                    ev[i] = 1'b1;
                bus_trk[i].thresh = {1'b0, s[i]} + {1'b0, cfg_qoffset};
            end
            addr_lvl = 1'b0;
        end else if (step_no % 2 == 0) begin
            for (int i = 0; i < 2; i++)
                if ({1'b0, s[i]} > bus_trk[i].thresh)
                    bus_trk[i].scan_exist = bus_trk[i].scan_exist | slot_sel;
            addr_lvl = 1'b1;
        end else begin
            for (int i = 0; i < 2; i++)
                if ({1'b0, s[i]} > bus_trk[i].thresh)
                    bus_trk[i].scan_active = bus_trk[i].scan_active | slot_sel[ACTIVE_W-1:0];
            slot_sel = slot_sel << 1;
            addr_lvl = 1'b0;
        end
        step_no++;
        if (step_no > SCAN_STEPS) begin
            step_no = 1;
            ev[0] = ev[0] | settle_bus(0, cfg_amask[0]);
            ev[1] = ev[1] | settle_bus(1, cfg_amask[1]);
        end
        r.bus_reset_pin   = reset_lvl;
        r.bus_address_pin = addr_lvl;
        r.exist_a         = bus_trk[0].pub_exist;
        r.active_a        = bus_trk[0].pub_active;
        r.latch_a         = bus_trk[0].latch;
        r.event_a         = ev[0];
        r.exist_b         = bus_trk[1].pub_exist;
        r.active_b        = bus_trk[1].pub_active;
        r.latch_b         = bus_trk[1].latch;
        r.event_b         = ev[1];
        r.change_tally_a  = bus_trk[0].tally;
        r.change_tally_b  = bus_trk[1].tally;
        return r;
    endfunction

    function automatic string scan_diffs(t_scan_out e, t_scan_out g);
        string d = "";
        if (e.bus_reset_pin !== g.bus_reset_pin)
            d = {d, $sformatf(" reset_pin %0h/%0h", e.bus_reset_pin, g.bus_reset_pin)};
        if (e.bus_address_pin !== g.bus_address_pin)
            d = {d, $sformatf(" address_pin %0h/%0h", e.bus_address_pin, g.bus_address_pin)};
        if (e.exist_a !== g.exist_a)
            d = {d, $sformatf(" exist_a %0h/%0h", e.exist_a, g.exist_a)};
        if (e.active_a !== g.active_a)
            d = {d, $sformatf(" active_a %0h/%0h", e.active_a, g.active_a)};
        if (e.latch_a !== g.latch_a)
            d = {d, $sformatf(" latch_a %0h/%0h", e.latch_a, g.latch_a)};
        if (e.event_a !== g.event_a)
            d = {d, $sformatf(" event_a %0h/%0h", e.event_a, g.event_a)};
        if (e.exist_b !== g.exist_b)
            d = {d, $sformatf(" exist_b %0h/%0h", e.exist_b, g.exist_b)};
        if (e.active_b !== g.active_b)
            d = {d, $sformatf(" active_b %0h/%0h", e.active_b, g.active_b)};
        if (e.latch_b !== g.latch_b)
            d = {d, $sformatf(" latch_b %0h/%0h", e.latch_b, g.latch_b)};
        if (e.event_b !== g.event_b)
            d = {d, $sformatf(" event_b %0h/%0h", e.event_b, g.event_b)};
        if (e.change_tally_a !== g.change_tally_a)
            d = {d, $sformatf(" tally_a %0h/%0h", e.change_tally_a, g.change_tally_a)};
        if (e.change_tally_b !== g.change_tally_b)
            d = {d, $sformatf(" tally_b %0h/%0h", e.change_tally_b, g.change_tally_b)};
        return d;
    endfunction

    always @(posedge clk) begin : scan_monitor
        t_scan_out due;
        t_scan_out got;
        string     diffs;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_QUIESCENT_OFFSET: cfg_qoffset    = cfg_data;
                    CFG_FAULT_HIGH_LIMIT: cfg_fault_hi   = cfg_data;
                    CFG_FAULT_LOW_LIMIT:  cfg_fault_lo   = cfg_data;
                    CFG_DEBOUNCE_SCANS:   cfg_debounce   = cfg_data[COUNT_W-1:0];
                    CFG_ASSERT_MASK_A:    cfg_amask[0]   = cfg_data[ACTIVE_W-1:0];
                    CFG_ASSERT_MASK_B:    cfg_amask[1]   = cfg_data[ACTIVE_W-1:0];
                    CFG_LATCH_MASK:       cfg_latch_mask = cfg_data[ACTIVE_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready) begin
                got = out_word;
                if (got.event_a || got.event_b)
                    events_seen++;
                if (scan_results_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result word with none due: %p", $realtime, got);
                    mismatches++;
                end else begin
                    due   = scan_results_due.pop_front();
                    diffs = scan_diffs(due, got);
                    results_checked++;
                    if (diffs != "") begin
                        if (mismatches < 10)
                            $display("%0t: result %0d mismatch (expected/actual):%s",
                                     $realtime, results_checked, diffs);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
                scan_results_due.push_back(predict_scan_tick(in_word));
        end
    end

    // hold ready low for a drawn stall, or for a requested long stretch
    initial begin : result_sink
        int stall;
        wait (rst_n);
        forever begin
            stall = stall_enable ? $urandom_range(0, 3) : 0;
            if (hold_cycles > 0) begin
                stall        = hold_cycles;
                longest_hold = hold_cycles;
                hold_cycles  = 0;
            end
            @(negedge clk);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    task automatic send_tick(logic [SAMPLE_BITS-1:0] a, logic [SAMPLE_BITS-1:0] b);
        int       gap;
        t_scan_in w;
        gap        = stall_enable ? $urandom_range(0, 3) : 0;
        w.sample_a = a;
        w.sample_b = b;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!(in_valid && in_ready));
        ticks_sent++;
    endtask

    task automatic send_noise(int n);
        repeat (n) send_tick(12'($urandom), 12'($urandom));
    endtask

    function automatic logic [SAMPLE_BITS-1:0] level_for(logic [THRESH_W-1:0] thr, logic on);
        if (thr >= 13'd4095)
            return 12'($urandom);
        if (on)
            return ($urandom_range(0, 3) == 0) ? thr[SAMPLE_BITS-1:0] + 12'd1
                                                : 12'($urandom_range(int'(thr) + 1, 4095));
        return ($urandom_range(0, 3) == 0) ? thr[SAMPLE_BITS-1:0]
                                            : 12'($urandom_range(0, int'(thr)));
    endfunction

    task automatic send_frame(logic [SAMPLE_BITS-1:0] qa, logic [SAMPLE_BITS-1:0] qb,
                              logic [EXIST_W-1:0] exa, logic [EXIST_W-1:0] exb,
                              logic [ACTIVE_W-1:0] aca, logic [ACTIVE_W-1:0] acb);
        logic [THRESH_W-1:0] thr_a;
        logic [THRESH_W-1:0] thr_b;
        int                  k;
        if (ticks_sent % SCAN_STEPS != 0)
            send_noise(SCAN_STEPS - ticks_sent % SCAN_STEPS);
        thr_a = {1'b0, qa} + {1'b0, cfg_qoffset};
        thr_b = {1'b0, qb} + {1'b0, cfg_qoffset};
        for (int st = 1; st <= SCAN_STEPS; st++) begin
            if (st < 3) begin
                send_noise(1);
            end else if (st == 3) begin
                send_tick(qa, qb);
            end else if (st % 2 == 0) begin
                k = (st - 4) / 2;
                send_tick(level_for(thr_a, exa[k]), level_for(thr_b, exb[k]));
            end else begin
                k = (st - 5) / 2;
                send_tick(level_for(thr_a, aca[k]), level_for(thr_b, acb[k]));
            end
        end
        frames_sent++;
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_quiescent();
        case ($urandom_range(0, 7))
            0:       return 12'($urandom);
            1, 2, 3: return 12'($urandom_range(0, 2047));
            default: return 12'($urandom_range(int'(cfg_fault_lo), int'(cfg_fault_hi)));
        endcase
    endfunction

    // repeat each pattern pair for up to max_repeat scans so the debounce can settle
    task automatic scan_bursts(int frames, int max_repeat);
        int                     done;
        int                     reps;
        logic [SAMPLE_BITS-1:0] qa;
        logic [SAMPLE_BITS-1:0] qb;
        logic [EXIST_W-1:0]     exa;
        logic [EXIST_W-1:0]     exb;
        logic [ACTIVE_W-1:0]    aca;
        logic [ACTIVE_W-1:0]    acb;
        done = 0;
        while (done < frames) begin
            qa   = pick_quiescent();
            qb   = pick_quiescent();
            exa  = 8'($urandom);
            exb  = 8'($urandom);
            aca  = ($urandom_range(0, 3) == 0) ? 7'($urandom) : exa[6:0] & 7'($urandom);
            acb  = ($urandom_range(0, 3) == 0) ? 7'($urandom) : exb[6:0] & 7'($urandom);
            reps = $urandom_range(1, max_repeat);
            for (int r = 0; r < reps && done < frames; r++) begin
                case ($urandom_range(0, 15))
                    0: begin
                        send_noise($urandom_range(1, 3));
                        send_frame(qa, qb, exa, exb, aca, acb);
                    end
                    1: send_frame(qa, qb, exa ^ (8'd1 << $urandom_range(0, 7)), exb,
                                  aca, acb ^ (7'd1 << $urandom_range(0, 6)));
                    2: send_noise(SCAN_STEPS);
                    default: send_frame(qa, qb, exa, exb, aca, acb);
                endcase
                done++;
            end
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (scan_results_due.size() != 0) @(posedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
    endtask

    task automatic apply_settings(logic [CFG_DATA_W-1:0] qoff, logic [CFG_DATA_W-1:0] hi,
                                  logic [CFG_DATA_W-1:0] lo, logic [CFG_DATA_W-1:0] deb,
                                  logic [CFG_DATA_W-1:0] ma, logic [CFG_DATA_W-1:0] mb,
                                  logic [CFG_DATA_W-1:0] lm);
        drain_results();
        write_reg(CFG_QUIESCENT_OFFSET, qoff);
        write_reg(CFG_FAULT_HIGH_LIMIT, hi);
        write_reg(CFG_FAULT_LOW_LIMIT, lo);
        write_reg(CFG_DEBOUNCE_SCANS, deb);
        write_reg(CFG_ASSERT_MASK_A, ma);
        write_reg(CFG_ASSERT_MASK_B, mb);
        write_reg(CFG_LATCH_MASK, lm);
        @(negedge clk);
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    task automatic test_directed_extremes();
        stall_enable = 1'b0;
        send_tick(12'd0, 12'd4095);
        send_tick(12'd4095, 12'd0);
        send_tick(12'd4095, 12'd0);
        for (int st = 4; st <= SCAN_STEPS; st++)
            send_tick((st % 2 == 0) ? 12'd4095 : 12'd0, (st % 4 < 2) ? 12'd1025 : 12'd1024);
        send_tick(12'hAAA, 12'h555);
        send_tick(12'h555, 12'hAAA);
        send_tick(12'd4095, 12'd4095);
        send_tick(12'd0, 12'd0);
    endtask

    task automatic test_default_settings();
        stall_enable = 1'b1;
        scan_bursts(12, 6);
    endtask

    task automatic test_debounce_short();
        apply_settings(12'd300, 12'd3000, 12'd100, 12'd0, 12'h07F, 12'h055, 12'h07F);
        stall_enable = 1'b0;
        scan_bursts(10, 3);
        apply_settings(12'd500, 12'd3500, 12'd200, 12'd1, 12'h02A, 12'h07F, 12'h03C);
        stall_enable = 1'b1;
        scan_bursts(10, 4);
    endtask

    task automatic test_debounce_long();
        apply_settings(12'd800, 12'd4000, 12'd50, 12'd15, 12'h07F, 12'h07F, 12'h07F);
        stall_enable = 1'b1;
        scan_bursts(16, 18);
    endtask

    task automatic test_threshold_extremes();
        apply_settings(12'd4095, 12'd0, 12'd4095, 12'd2, 12'h07F, 12'h07F, 12'h07F);
        stall_enable = 1'b0;
        scan_bursts(6, 3);
        apply_settings(12'd0, 12'd4095, 12'd0, 12'd2, 12'h000, 12'h000, 12'h000);
        stall_enable = 1'b1;
        scan_bursts(8, 4);
    endtask

    task automatic test_event_masks_and_latch();
        apply_settings(12'd200, 12'd3800, 12'd0, 12'd1, 12'h07F, 12'h07F, 12'h07F);
        stall_enable = 1'b1;
        scan_bursts(10, 3);
        apply_settings(12'd200, 12'd3800, 12'd0, 12'hFF2, 12'hF80, 12'h03F, 12'hF81);
        stall_enable = 1'b0;
        scan_bursts(8, 3);
    endtask

    task automatic test_output_backpressure();
        stall_enable = 1'b0;
        hold_cycles  = 150;
        scan_bursts(4, 3);
    endtask

    task automatic test_random_settings();
        repeat (6) begin
            apply_settings(12'($urandom_range(0, 2047)), 12'($urandom_range(2048, 4095)),
                           12'($urandom_range(0, 1023)), 12'($urandom_range(0, 4095)),
                           12'($urandom), 12'($urandom), 12'($urandom));
            stall_enable = ($urandom_range(0, 2) != 0);
            scan_bursts(3, 5);
        end
    endtask

    initial begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        in_word          = '0;
        out_ready        = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        mismatches       = 0;
        results_checked  = 0;
        ticks_sent       = 0;
        frames_sent      = 0;
        settings_applied = 0;
        events_seen      = 0;
        cycle_count      = 0;
        hold_cycles      = 0;
        longest_hold     = 0;
        stall_enable     = 1'b0;
        reset_predictor();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_extremes();
        test_default_settings();
        test_debounce_short();
        test_debounce_long();
        test_threshold_extremes();
        test_event_masks_and_latch();
        test_output_backpressure();
        test_random_settings();

        drain_results();
        repeat (5) @(posedge clk);
        if (scan_results_due.size() != 0) begin
            $display("%0d result words never arrived", scan_results_due.size());
            mismatches += scan_results_due.size();
        end
        $display("Ran %0d scan ticks (%0d aligned frames) over %0d register settings.",
                 ticks_sent, frames_sent, settings_applied);
        $display("Checked %0d results, %0d with events; longest output hold %0d cycles.",
                 results_checked, events_seen, longest_hold);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
